@@ src/bsa_pkg.sv @@
package bsa_pkg;

    localparam int MAX_SLOTS = 4096;
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int ENT_W     = 13;
    localparam int SIZE_W    = 17;
    localparam int OFS_W     = 28;
    localparam int SPAN_W    = ENT_W + SIZE_W;
    localparam int DSH_W     = SIZE_W + ENT_W - 1;
    localparam int DCNT_W    = 4;
    localparam int GLEN_W    = 4;
    localparam int ST_W      = 2;
    localparam int GRP_W     = 5;
    localparam int CFG_W     = SIZE_W;
    localparam int CFG_IDX_W = 1;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 48;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd64;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 17'd8;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;
    localparam int                ENT_RESET  = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 1'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic            start;
        logic            scan_init;
        logic            scan_step;
        logic            grant;
        logic            mul_grant;
        logic            mul_span;
        logic            take_offset;
        logic            div_init;
        logic            div_step;
        logic            rd_free;
        logic            free_commit;
        logic            set_status;
        logic [ST_W-1:0] status_code;
        logic            clr_init;
        logic            clr_step;
        logic            load_out;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic found;
        logic exhausted;
        logic out_of_range;
        logic div_last;
        logic bit_set;
        logic clr_last;
        logic out_busy;
    } stat_t;

endpackage

@@ src/bsa_ctrl.sv @@
module bsa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           opcode,
    input  logic           cfg_clear,
    input  bsa_pkg::stat_t stat,
    output logic           s_tready,
    output bsa_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_SCAN      = 4'd2;
    localparam logic [3:0] S_GRANT_MUL = 4'd3;
    localparam logic [3:0] S_GRANT_WB  = 4'd4;
    localparam logic [3:0] S_RANGE     = 4'd5;
    localparam logic [3:0] S_DIV       = 4'd6;
    localparam logic [3:0] S_READ      = 4'd7;
    localparam logic [3:0] S_TEST      = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE) && !cfg_clear;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (cfg_clear)
                begin
                    cmd.clr_init = 1'b1;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                    if (stat.clr_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (cfg_clear)
                begin
                    cmd.clr_init = 1'b1;
                    state_next   = S_CLEAR;
                end
                else if (accept)
                begin
                    cmd.start = 1'b1;
                    if (opcode == bsa_pkg::OP_ALLOC)
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = bsa_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    else
                    begin
                        // span = entries * slot size, compared next cycle
                        cmd.mul_span = 1'b1;
                        state_next   = S_RANGE;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.found)
                begin
                    cmd.grant  = 1'b1;
                    state_next = S_GRANT_MUL;
                end
                else if (stat.exhausted)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = bsa_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
            end
            S_GRANT_MUL:
            begin
                cmd.mul_grant = 1'b1;
                state_next    = S_GRANT_WB;
            end
            S_GRANT_WB:
            begin
                cmd.take_offset = 1'b1;
                state_next      = S_DONE;
            end
            S_RANGE:
            begin
                if (stat.out_of_range)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = bsa_pkg::ST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_free = 1'b1;
                state_next  = S_TEST;
            end
            S_TEST:
            begin
                if (stat.bit_set)
                begin
                    cmd.free_commit = 1'b1;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = bsa_pkg::ST_NOT_ALLOC;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transfer did not start work");

endmodule

@@ src/bsa_datapath.sv @@
module bsa_datapath #(
    parameter int GROUP_COUNT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsa_pkg::CFG_W-1:0]      cfg_data,
    input  logic [bsa_pkg::OFS_W-1:0]      free_offset,
    input  logic                           m_tready,
    input  bsa_pkg::cmd_t                  cmd,
    output bsa_pkg::stat_t                 stat,
    output logic                           m_tvalid,
    output logic [bsa_pkg::OUT_W-1:0]      m_tdata
);

    localparam int MAX_SLOTS  = bsa_pkg::MAX_SLOTS;
    localparam int WORD_COUNT = (MAX_SLOTS + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WCNT_W     = WIDX_W + 1;
    localparam int ENT_RST    = (MAX_SLOTS < bsa_pkg::ENT_RESET) ? MAX_SLOTS
                                                                 : bsa_pkg::ENT_RESET;

    localparam int WB  = bsa_pkg::WORD_BITS;
    localparam int EW  = bsa_pkg::ENT_W;
    localparam int SW  = bsa_pkg::SIZE_W;
    localparam int OW  = bsa_pkg::OFS_W;
    localparam int BW  = bsa_pkg::BIT_W;
    localparam int GW  = bsa_pkg::GRP_W;

    // configuration
    logic [EW-1:0] entries_reg;
    logic [SW-1:0] slot_bytes_reg;
    logic [EW-1:0] ent_wr;
    logic [SW-1:0] size_wr;

    // bitmap memory
    logic [WB-1:0]     mem [WORD_COUNT];
    logic [WB-1:0]     rd_data_reg;
    logic              mem_we;
    logic [WIDX_W-1:0] mem_wa;
    logic [WB-1:0]     mem_wd;
    logic              mem_re;
    logic [WIDX_W-1:0] mem_ra;

    // pool state
    logic [WIDX_W-1:0] hint_reg;
    logic [EW-1:0]     used_reg;
    logic [WIDX_W-1:0] clr_ptr_reg;

    // scan
    logic [WIDX_W-1:0] ptr_reg;
    logic [WCNT_W-1:0] issue_cnt_reg;
    logic [WIDX_W-1:0] rd_word_reg;
    logic              rd_valid_reg;
    logic              issue_ok;

    // request / result
    logic [OW-1:0]            offset_reg;
    logic [bsa_pkg::ST_W-1:0] res_status_reg;
    logic [OW-1:0]            res_offset_reg;
    logic [EW-1:0]            slot_idx_reg;
    logic [bsa_pkg::SPAN_W-1:0] mul_reg;
    logic [EW-1:0]            mul_a;

    // divider
    logic [OW-1:0]                  rem_reg;
    logic [bsa_pkg::DSH_W-1:0]      dsh_reg;
    logic [EW-1:0]                  q_reg;
    logic [bsa_pkg::DCNT_W-1:0]     div_cnt_reg;
    logic                           div_ge;

    // output stage
    logic                     out_valid_reg;
    logic [bsa_pkg::ST_W-1:0] out_status_reg;
    logic [OW-1:0]            out_offset_reg;
    logic [EW-1:0]            out_used_reg;
    logic [GW-1:0]            out_group_reg;

    // derived
    logic [EW:0]       ent_round;
    logic [WCNT_W-1:0] words;
    logic [BW-1:0]     tail;
    logic [WB-1:0]     clr_data;
    logic              clr_is_last;
    logic [WB-1:0]     vacant;
    logic [WB-1:0]     low_bit;
    logic [BW-1:0]     low_idx;
    logic [WIDX_W-1:0] free_word;
    logic [BW-1:0]     free_bit;
    logic [EW-1:0]     avail_cnt;
    logic [EW-1:0]     free_m1;
    logic [bsa_pkg::GLEN_W-1:0] glen;
    logic [GW-1:0]     group;

    function automatic logic [WIDX_W-1:0] wrap_next(input logic [WIDX_W-1:0] w,
                                                     input logic [WCNT_W-1:0] n);
        logic [WCNT_W-1:0] p1;
        p1 = {1'b0, w} + 1'b1;
        return (p1 == n) ? '0 : p1[WIDX_W-1:0];
    endfunction

    assign ent_round   = {1'b0, entries_reg} + (EW + 1)'(WB - 1);
    assign words       = WCNT_W'(ent_round >> BW);
    assign tail        = entries_reg[BW-1:0];
    assign clr_is_last = (({1'b0, clr_ptr_reg} + 1'b1) == words);
    assign clr_data    = (clr_is_last && (tail != '0)) ? ({WB{1'b1}} << tail) : '0;

    assign issue_ok = (issue_cnt_reg != words);
    assign vacant   = ~rd_data_reg;
    assign low_bit  = vacant & (~vacant + 1'b1);

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < WB; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | BW'(i);
            end
        end
    end

    assign free_word = WIDX_W'(q_reg >> BW);
    assign free_bit  = q_reg[BW-1:0];

    always_comb
    begin
        ent_wr = cfg_data[EW-1:0];
        if (ent_wr == '0)
        begin
            ent_wr = EW'(1);
        end
        else if (32'(ent_wr) > MAX_SLOTS)
        begin
            ent_wr = EW'(MAX_SLOTS);
        end
        size_wr = cfg_data[SW-1:0];
        if (size_wr < bsa_pkg::SIZE_MIN)
        begin
            size_wr = bsa_pkg::SIZE_MIN;
        end
        else if (size_wr > bsa_pkg::SIZE_MAX)
        begin
            size_wr = bsa_pkg::SIZE_MAX;
        end
    end

    // memory port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
            mem_wa = clr_ptr_reg;
            mem_wd = clr_data;
        end
        else if (cmd.grant)
        begin
            mem_we = 1'b1;
            mem_wa = rd_word_reg;
            mem_wd = rd_data_reg | low_bit;
        end
        else if (cmd.free_commit)
        begin
            mem_we = 1'b1;
            mem_wa = free_word;
            mem_wd = rd_data_reg & ~(WB'(1) << free_bit);
        end
        mem_re = (cmd.scan_step && issue_ok) || cmd.rd_free;
        mem_ra = cmd.scan_step ? ptr_reg : free_word;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign div_ge = (bsa_pkg::DSH_W'(rem_reg) >= dsh_reg);
    assign mul_a  = cmd.mul_span ? entries_reg : slot_idx_reg;

    // free-count group: bit length of (free - 1), clamped
    assign avail_cnt = entries_reg - used_reg;
    assign free_m1   = avail_cnt - 1'b1;

    always_comb
    begin
        glen = '0;
        for (int i = 0; i < EW; i++)
        begin
            if (free_m1[i])
            begin
                glen = bsa_pkg::GLEN_W'(i + 1);
            end
        end
        if (avail_cnt == '0)
        begin
            group = '1;
        end
        else if (32'(glen) > GROUP_COUNT - 1)
        begin
            group = GW'(GROUP_COUNT - 1);
        end
        else
        begin
            group = GW'(glen);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg    <= EW'(ENT_RST);
            slot_bytes_reg <= bsa_pkg::SIZE_RESET;
            hint_reg       <= '0;
            used_reg       <= '0;
            clr_ptr_reg    <= '0;
            ptr_reg        <= '0;
            issue_cnt_reg  <= '0;
            rd_word_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == bsa_pkg::REG_ENTRIES))
            begin
                entries_reg <= ent_wr;
            end
            if (cfg_we && (cfg_index == bsa_pkg::REG_SLOT_BYTES))
            begin
                slot_bytes_reg <= size_wr;
            end

            if (cmd.clr_init)
            begin
                clr_ptr_reg <= '0;
                hint_reg    <= '0;
                used_reg    <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end

            if (cmd.scan_init)
            begin
                ptr_reg       <= hint_reg;
                issue_cnt_reg <= '0;
                rd_valid_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_valid_reg <= issue_ok;
                if (issue_ok)
                begin
                    rd_word_reg   <= ptr_reg;
                    ptr_reg       <= wrap_next(ptr_reg, words);
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
            end

            if (cmd.grant)
            begin
                used_reg <= used_reg + 1'b1;
                hint_reg <= wrap_next(rd_word_reg, words);
            end
            else if (cmd.free_commit && (used_reg != '0))
            begin
                used_reg <= used_reg - 1'b1;
            end

            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            offset_reg     <= free_offset;
            res_offset_reg <= '0;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
        else if (cmd.start)
        begin
            res_status_reg <= bsa_pkg::ST_OK;
        end
        if (cmd.grant)
        begin
            slot_idx_reg <= EW'({rd_word_reg, low_idx});
        end
        if (cmd.mul_span || cmd.mul_grant)
        begin
            mul_reg <= bsa_pkg::SPAN_W'(mul_a) * bsa_pkg::SPAN_W'(slot_bytes_reg);
        end
        if (cmd.take_offset)
        begin
            res_offset_reg <= mul_reg[OW-1:0];
        end
        // restoring divide, one quotient bit per cycle
        if (cmd.div_init)
        begin
            rem_reg <= offset_reg;
            dsh_reg <= bsa_pkg::DSH_W'(slot_bytes_reg) << (EW - 1);
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - OW'(dsh_reg);
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[EW-2:0], div_ge};
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_offset_reg <= res_offset_reg;
            out_used_reg   <= used_reg;
            out_group_reg  <= group;
        end
    end

    always_comb
    begin
        stat.full         = (used_reg >= entries_reg);
        stat.found        = rd_valid_reg && (vacant != '0);
        stat.exhausted    = !rd_valid_reg && !issue_ok;
        stat.out_of_range = (bsa_pkg::SPAN_W'(offset_reg) >= mul_reg);
        stat.div_last     = (div_cnt_reg == bsa_pkg::DCNT_W'(EW - 1));
        stat.bit_set      = rd_data_reg[free_bit];
        stat.clr_last     = clr_is_last;
        stat.out_busy     = out_valid_reg && !m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_group_reg, out_used_reg, out_offset_reg, out_status_reg};

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= entries_reg)
        else $error("slot count above entry count");

    a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |=> used_reg == $past(used_reg) + 1'b1)
        else $error("grant did not bump slot count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && !m_tready))
        else $error("pending result overwritten");

endmodule

@@ src/bitmap_slot_allocator_top.sv @@
// Slot pool allocator with a next-fit bitmap.
// Request channel s_*: s_tuser[0] is the opcode (0 allocate, 1 free) and
// s_tdata[27:0] the byte offset to free. Result channel m_*: one result per
// request, fields packed in m_tdata. Config port: cfg_we writes cfg_data into
// register cfg_index (0 entry count, which also clears the pool; 1 slot size).
// Allocate scans bitmap words from the hint until a free bit turns up, at
// worst ceil(entries/64) words; the scan reads one word per cycle through the
// bitmap memory port, then the slot index times the slot size gives the offset.
// Free checks the offset against the pool span, and the 13-step radix-2
// divider turns the offset into a slot index. A full pool answers without a
// scan, an out-of-range offset after the span check. One request is in flight
// at a time; the next one is taken the cycle after the result is loaded.
// After reset, and after an entry count write made while idle or clearing, a clearing pass writes
// ceil(entries/64) bitmap words, one per cycle, with s_tready low.
// The result sits in an output register; a new request is accepted while it
// waits, but the next result is held back until the receiver takes it.
module bitmap_slot_allocator_top #(
    parameter int GROUP_COUNT = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bsa_pkg::IN_W-1:0]      s_tdata,   // [27:0] free_offset
    input  logic [0:0]                    s_tuser,   // [0] opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [29:2] slot_offset, [42:30] used_count, [47:43] free-count group
    output logic [bsa_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsa_pkg::CFG_W-1:0]     cfg_data
);

    bsa_pkg::cmd_t  cmd;
    bsa_pkg::stat_t stat;
    logic           cfg_clear;

    assign cfg_clear = cfg_we && (cfg_index == bsa_pkg::REG_ENTRIES);

    bsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .opcode    (s_tuser[0]),
        .cfg_clear (cfg_clear),
        .stat      (stat),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    bsa_datapath #(
        .GROUP_COUNT (GROUP_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .free_offset (s_tdata[bsa_pkg::OFS_W-1:0]),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int POOL_MAX    = bsa_pkg::MAX_SLOTS;
    localparam int GROUP_COUNT = 16;
    localparam int MAP_WORDS   = POOL_MAX / bsa_pkg::WORD_BITS;

    // Same order as m_tdata, highest field first.
    typedef struct packed {
        logic [bsa_pkg::GRP_W-1:0] free_grp;
        logic [bsa_pkg::ENT_W-1:0] used_count;
        logic [bsa_pkg::OFS_W-1:0] slot_offset;
        logic [bsa_pkg::ST_W-1:0]  status;
    } result_t;

    typedef struct {
        bit                            is_cfg;
        logic [bsa_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [bsa_pkg::CFG_W-1:0]     reg_val;
        logic                          op;
        logic [bsa_pkg::OFS_W-1:0]     ofs;
        bit                            typed;
        result_t                       want;
    } step_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bsa_pkg::IN_W-1:0]      s_tdata;   // [27:0] free_offset
    logic [0:0]                    s_tuser;   // [0] opcode
    logic                          m_tvalid;
    logic                          m_tready;
    // [1:0] status, [29:2] slot_offset, [42:30] used_count, [47:43] free-count group
    logic [bsa_pkg::OUT_W-1:0]     m_tdata;
    logic                          cfg_we;
    logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bsa_pkg::CFG_W-1:0]     cfg_data;

    // Shadow of the pool.
    logic [bsa_pkg::WORD_BITS-1:0] pool_map [MAP_WORDS];
    int unsigned          hint_word;
    int unsigned          in_use;
    int unsigned          pool_size;
    int unsigned          slot_size;

    result_t pending_results [$];
    step_t   plan [$];
    int      fails;
    bit      gap_off;

    bitmap_slot_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned words_live();
        return (pool_size + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
    endfunction

    // Bits of the last word past the pool end stay set so the scan never grants them.
    function automatic void pool_clear();
        int unsigned tail;
        int          i;
        tail = pool_size % bsa_pkg::WORD_BITS;
        for (i = 0; i < MAP_WORDS; i++)
            pool_map[i] = '0;
        if (tail != 0)
            pool_map[words_live() - 1] = ~((64'd1 << tail) - 64'd1);
        hint_word = 0;
        in_use    = 0;
    endfunction

    function automatic void apply_cfg(logic [bsa_pkg::CFG_IDX_W-1:0] idx,
                                      logic [bsa_pkg::CFG_W-1:0] val);
        int unsigned v;
        if (idx == bsa_pkg::REG_ENTRIES)
        begin
            v = 32'(val[bsa_pkg::ENT_W-1:0]);
            if (v < 1)
                v = 1;
            if (v > POOL_MAX)
                v = POOL_MAX;
            pool_size = v;
            pool_clear();
        end
        else
        begin
            v = 32'(val);
            if (v < bsa_pkg::SIZE_MIN)
                v = bsa_pkg::SIZE_MIN;
            if (v > bsa_pkg::SIZE_MAX)
                v = bsa_pkg::SIZE_MAX;
            slot_size = v;
        end
    endfunction

    function automatic logic [bsa_pkg::GRP_W-1:0] group_of_left();
        int unsigned left;
        int unsigned g;
        left = pool_size - in_use;
        if (left == 0)
            return '1;
        g = 0;
        while (g < 31 && (32'd1 << g) < left)
            g++;
        if (g > GROUP_COUNT - 1)
            g = GROUP_COUNT - 1;
        return g[bsa_pkg::GRP_W-1:0];
    endfunction

    function automatic result_t pool_predict(logic op, logic [bsa_pkg::OFS_W-1:0] ofs);
        result_t           r;
        int unsigned       words;
        int unsigned       w;
        int unsigned       b;
        int unsigned       i;
        int unsigned       idx;
        longint unsigned   span;
        longint unsigned   granted;
        bit                found;
        r.status      = bsa_pkg::ST_OK;
        r.slot_offset = '0;
        if (op == bsa_pkg::OP_ALLOC)
        begin
            words = words_live();
            if (in_use >= pool_size)
                r.status = bsa_pkg::ST_FULL;
            else
            begin
                found = 1'b0;
                for (i = 0; i < words && !found; i++)
                begin
                    w = (hint_word % words + i) % words;
                    if (~pool_map[w] != '0)
                    begin
                        b = 0;
                        while (pool_map[w][b])
                            b++;
                        pool_map[w][b] = 1'b1;
                        in_use++;
                        hint_word = (w + 1) % words;
                        granted = 64'(w);
                        granted = (granted * bsa_pkg::WORD_BITS + b) * slot_size;
                        r.slot_offset = granted[bsa_pkg::OFS_W-1:0];
                        found = 1'b1;
                    end
                end
                if (!found)
                    r.status = bsa_pkg::ST_FULL;
            end
        end
        else
        begin
            span = longint'(pool_size) * slot_size;
            if (ofs >= span)
                r.status = bsa_pkg::ST_RANGE;
            else
            begin
                idx = ofs / slot_size;
                w   = idx / bsa_pkg::WORD_BITS;
                b   = idx % bsa_pkg::WORD_BITS;
                if (!pool_map[w][b])
                    r.status = bsa_pkg::ST_NOT_ALLOC;
                else
                begin
                    pool_map[w][b] = 1'b0;
                    if (in_use > 0)
                        in_use--;
                end
            end
        end
        r.used_count = in_use[bsa_pkg::ENT_W-1:0];
        r.free_grp   = group_of_left();
        return r;
    endfunction

    // Mostly frees of live slots (some mid-slot), plus stale, out-of-range and raw offsets.
    function automatic logic [bsa_pkg::OFS_W-1:0] pick_free_offset();
        longint unsigned span;
        longint unsigned v;
        int unsigned     idx;
        int unsigned     pick;
        int unsigned     tries;
        span = longint'(pool_size) * slot_size;
        pick = $urandom_range(0, 99);
        if (pick < 65 && in_use > 0)
        begin
            idx   = $urandom_range(0, pool_size - 1);
            tries = 0;
            while (!pool_map[idx / bsa_pkg::WORD_BITS][idx % bsa_pkg::WORD_BITS]
                   && tries < 40)
            begin
                idx = $urandom_range(0, pool_size - 1);
                tries++;
            end
            v = longint'(idx) * slot_size;
            if ($urandom_range(0, 1))
                v += $urandom_range(0, slot_size - 1);
        end
        else if (pick < 80)
            v = $urandom() % span;
        else if (pick < 90 && span < (64'd1 << bsa_pkg::OFS_W))
            v = span + $urandom() % ((64'd1 << bsa_pkg::OFS_W) - span);
        else
            v = 64'($urandom());
        return v[bsa_pkg::OFS_W-1:0];
    endfunction

    task automatic note_mismatch(input string msg);
        fails++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic plan_cfg(input logic [bsa_pkg::CFG_IDX_W-1:0] idx,
                            input logic [bsa_pkg::CFG_W-1:0] val);
        step_t s;
        s = '{default: 0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        plan.insert(plan.size(), s);
    endtask

    task automatic plan_req(input logic op, input logic [bsa_pkg::OFS_W-1:0] ofs);
        step_t s;
        s = '{default: 0};
        s.op  = op;
        s.ofs = ofs;
        plan.insert(plan.size(), s);
    endtask

    task automatic plan_chk(input logic op, input logic [bsa_pkg::OFS_W-1:0] ofs,
                            input logic [bsa_pkg::ST_W-1:0] st, input int so,
                            input int uc, input int fg);
        step_t s;
        s = '{default: 0};
        s.op    = op;
        s.ofs   = ofs;
        s.typed = 1'b1;
        s.want.status      = st;
        s.want.slot_offset = bsa_pkg::OFS_W'(so);
        s.want.used_count  = bsa_pkg::ENT_W'(uc);
        s.want.free_grp    = bsa_pkg::GRP_W'(fg);
        plan.insert(plan.size(), s);
    endtask

    task automatic send_req(input logic op, input logic [bsa_pkg::OFS_W-1:0] ofs,
                            input bit typed, input result_t want);
        int      gap;
        result_t model;
        gap = gap_off ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= bsa_pkg::IN_W'(ofs);
        do @(posedge clk); while (!s_tready);
        model = pool_predict(op, ofs);
        pending_results.insert(pending_results.size(), typed ? want : model);
    endtask

    // Hold off until every result is back and the block can take a request.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [bsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bsa_pkg::CFG_W-1:0] val);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        apply_cfg(idx, val);
    endtask

    // Result side: random stall before each transfer.
    initial
    begin
        int pause;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            pause = gap_off ? 0 : $urandom_range(0, 11);
            @(negedge clk);
            if (pause > 0)
            begin
                m_tready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin
        result_t seen;
        result_t hoped;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = result_t'(m_tdata);
            if (pending_results.size() == 0)
                note_mismatch($sformatf("result with nothing pending: %h", m_tdata));
            else
            begin
                hoped = pending_results.pop_front();
                if (seen !== hoped)
                    note_mismatch($sformatf(
                        "got st=%0d ofs=%0h used=%0d grp=%0d, want st=%0d ofs=%0h used=%0d grp=%0d",
                        seen.status, seen.slot_offset, seen.used_count,
                        $signed(seen.free_grp), hoped.status, hoped.slot_offset,
                        hoped.used_count, $signed(hoped.free_grp)));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("bitmap_slot_allocator_top: mismatch");
        $finish;
    end

    initial
    begin
        int          phase;
        int          n;
        int          count;
        int          alloc_pct;
        int          spin;
        logic [bsa_pkg::CFG_W-1:0] ent;
        logic [bsa_pkg::CFG_W-1:0] sz;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gap_off   = 1'b0;
        fails     = 0;
        pool_size = bsa_pkg::ENT_RESET;
        slot_size = 32'(bsa_pkg::SIZE_RESET);
        pool_clear();

        // Reset values: 4096 slots of 64 bytes.
        plan_chk(bsa_pkg::OP_ALLOC, 28'd0, bsa_pkg::ST_OK, 0, 1, 12);
        plan_req(bsa_pkg::OP_ALLOC, 28'd0);
        plan_req(bsa_pkg::OP_ALLOC, 28'hFFFFFFF);
        plan_req(bsa_pkg::OP_FREE, 28'd0);
        plan_chk(bsa_pkg::OP_FREE, 28'd0, bsa_pkg::ST_NOT_ALLOC, 0, 2, 12);
        plan_chk(bsa_pkg::OP_FREE, 28'hFFFFFFF, bsa_pkg::ST_RANGE, 0, 2, 12);
        plan_req(bsa_pkg::OP_FREE, 28'd4159);                        // inside slot 64
        plan_chk(bsa_pkg::OP_FREE, 28'd262143, bsa_pkg::ST_NOT_ALLOC, 0, 1, 12);
        // Below-range values clamp: one slot of 8 bytes.
        plan_cfg(bsa_pkg::REG_SLOT_BYTES, 17'd0);
        plan_cfg(bsa_pkg::REG_ENTRIES, 17'd0);
        plan_chk(bsa_pkg::OP_ALLOC, 28'd0, bsa_pkg::ST_OK, 0, 1, -1);
        plan_chk(bsa_pkg::OP_ALLOC, 28'd0, bsa_pkg::ST_FULL, 0, 1, -1);
        plan_chk(bsa_pkg::OP_FREE, 28'd8, bsa_pkg::ST_RANGE, 0, 1, -1);
        plan_chk(bsa_pkg::OP_FREE, 28'd7, bsa_pkg::ST_OK, 0, 0, 0);
        plan_chk(bsa_pkg::OP_FREE, 28'd0, bsa_pkg::ST_NOT_ALLOC, 0, 0, 0);
        // Above-range values clamp: 4096 slots of 64 KiB, span covers all offsets.
        plan_cfg(bsa_pkg::REG_SLOT_BYTES, 17'h1FFFF);
        plan_cfg(bsa_pkg::REG_ENTRIES, 17'h1FFFF);
        plan_chk(bsa_pkg::OP_FREE, 28'hFFFFFFF, bsa_pkg::ST_NOT_ALLOC, 0, 0, 12);
        plan_chk(bsa_pkg::OP_ALLOC, 28'd0, bsa_pkg::ST_OK, 0, 1, 12);
        plan_req(bsa_pkg::OP_ALLOC, 28'd0);
        // Partial last word, slot size not a power of two.
        plan_cfg(bsa_pkg::REG_SLOT_BYTES, 17'd100);
        plan_cfg(bsa_pkg::REG_ENTRIES, 17'd65);
        plan_req(bsa_pkg::OP_ALLOC, 28'd0);
        plan_req(bsa_pkg::OP_ALLOC, 28'd0);
        plan_req(bsa_pkg::OP_ALLOC, 28'd0);
        plan_req(bsa_pkg::OP_FREE, 28'd150);
        plan_req(bsa_pkg::OP_FREE, 28'd6499);
        plan_chk(bsa_pkg::OP_FREE, 28'd6500, bsa_pkg::ST_RANGE, 0, 1, 6);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_req(plan[i].op, plan[i].ofs, plan[i].typed, plan[i].want);
        end

        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 6)
                0:       ent = $urandom_range(0, 1) ? 17'd4096 : 17'h1FFFF;
                1:       ent = bsa_pkg::CFG_W'($urandom_range(1, 64));
                2:       ent = bsa_pkg::CFG_W'($urandom_range(65, 300));
                3:       ent = bsa_pkg::CFG_W'($urandom_range(1, 4096));
                4:       ent = bsa_pkg::CFG_W'($urandom_range(0, 2));
                default: ent = bsa_pkg::CFG_W'($urandom());
            endcase
            case (phase % 7)
                0:       sz = bsa_pkg::SIZE_MIN;
                1:       sz = bsa_pkg::SIZE_MAX;
                2:       sz = bsa_pkg::CFG_W'($urandom_range(8, 65536));
                3:       sz = 17'd1 << $urandom_range(3, 16);
                4:       sz = bsa_pkg::CFG_W'($urandom_range(0, 7));
                5:       sz = bsa_pkg::CFG_W'($urandom_range(65537, 131071));
                default: sz = bsa_pkg::CFG_W'($urandom_range(9, 200));
            endcase
            case ($urandom_range(0, 3))
                0:       alloc_pct = 30;
                1:       alloc_pct = 50;
                2:       alloc_pct = 70;
                default: alloc_pct = 90;
            endcase
            count = 175;
            // Last phase: allocate-only on the largest pool to reach the top offsets.
            if (phase == 11)
            begin
                ent       = 17'd4096;
                sz        = bsa_pkg::SIZE_MAX;
                alloc_pct = 100;
                count     = 90;
            end
            write_reg(bsa_pkg::REG_SLOT_BYTES, sz);
            write_reg(bsa_pkg::REG_ENTRIES, ent);
            gap_off = ($urandom_range(0, 3) == 0);
            for (n = 0; n < count; n++)
            begin
                if ($urandom_range(0, 149) == 0)
                    settle();
                if ($urandom_range(0, 99) < alloc_pct)
                    send_req(bsa_pkg::OP_ALLOC, bsa_pkg::OFS_W'($urandom()), 1'b0, '0);
                else
                    send_req(bsa_pkg::OP_FREE, pick_free_offset(), 1'b0, '0);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        for (spin = 0; spin < 5000 && pending_results.size() != 0; spin++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (fails == 0)
            $display("bitmap_slot_allocator_top: match");
        else
            $display("bitmap_slot_allocator_top: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
src/bsa_pkg.sv
src/bsa_ctrl.sv
src/bsa_datapath.sv
src/bitmap_slot_allocator_top.sv
tb/tb.sv
